FILE: hw/rtl/tllpp_pkg.sv
// ----------------------------------------------------------------------------
// tllpp_pkg
// Shared types and constants of the threshold least-load peer picker.
// ----------------------------------------------------------------------------
package tllpp_pkg;

   localparam int MAX_PEERS   = 512;
   localparam int IDX_W       = $clog2(MAX_PEERS);
   localparam int CNT_W       = $clog2(MAX_PEERS + 1);
   localparam int ACT_W       = 32;
   localparam int PEND_W      = 48;
   localparam int LEN_W       = 32;
   localparam int RND_W       = 31;
   localparam int PEER_W      = 9;
   localparam int NPEER_W     = 10;
   localparam logic [ACT_W-1:0] DEFAULT_THRESHOLD = 32'd24;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_PEERS = 2'd1;
   localparam logic [1:0] STATUS_RANGE    = 2'd2;

   localparam logic FUNC_ASSIGN  = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_PEERS     = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_MIN,
      ST_MOD,
      ST_SEL,
      ST_RMW_RD,
      ST_RMW_WR,
      ST_DONE
   } state_type;

   // divider control between the top level and the modulo unit
   typedef struct packed {
      logic            start;
      logic [RND_W-1:0] dividend;
      logic [CNT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic            done;
      logic [CNT_W-1:0] remainder;
   } div_rsp_type;

endpackage

FILE: hw/rtl/tllpp_mod.sv
// ----------------------------------------------------------------------------
// tllpp_mod
// Bit-serial remainder unit: one dividend bit per cycle, restoring form.
// ----------------------------------------------------------------------------
module tllpp_mod (
   input  logic                  clock,
   input  logic                  reset,
   input  tllpp_pkg::div_req_type req,
   output tllpp_pkg::div_rsp_type rsp
);
   import tllpp_pkg::*;

   localparam int STEP_W = $clog2(RND_W + 1);

   logic [RND_W-1:0] dvd_ff, dvd_in;
   logic [CNT_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W:0]   rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W:0]   shifted;

   // one shift and conditional subtract per cycle
   always_comb begin
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[CNT_W-1:0], dvd_ff[RND_W-1]};
      if (req.start) begin
         dvd_in  = req.dividend;
         dvs_in  = req.divisor;
         rem_in  = '0;
         step_in = STEP_W'(RND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[RND_W-2:0], 1'b0};
         if (shifted >= {1'b0, dvs_ff}) rem_in = shifted - {1'b0, dvs_ff};
         else rem_in = shifted;
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff[CNT_W-1:0];

endmodule

FILE: hw/rtl/threshold_least_load_peer_picker.sv
// ----------------------------------------------------------------------------
// threshold_least_load_peer_picker
// Least-load peer picker with an overload threshold, counters held in RAM.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears on the rsp_ ports for one cycle with rsp_valid and cannot be held
// off. After reset the block clears all MAX_PEERS (512) entries of both
// counter memories with busy high. A release goes through ST_RMW_RD,
// ST_RMW_WR and ST_DONE before its result shows. An assign streams the peers
// in use through the single memory read port twice (overload check together
// with the minimum, then selection), with the bit-serial remainder between
// the two passes.
// ----------------------------------------------------------------------------
module threshold_least_load_peer_picker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_func,
   input  logic [tllpp_pkg::PEER_W-1:0]  req_peer_index,
   input  logic [tllpp_pkg::LEN_W-1:0]   req_job_len,
   input  logic [tllpp_pkg::RND_W-1:0]   req_random_value,
   output logic                          rsp_valid,
   output logic [tllpp_pkg::PEER_W-1:0]  rsp_chosen_peer,
   output logic                          rsp_all_overloaded,
   output logic [1:0]                    rsp_status,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [31:0]                   csr_data
);
   import tllpp_pkg::*;

   // configuration registers
   logic [ACT_W-1:0]   thr_ff;
   logic [NPEER_W-1:0] npeers_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= DEFAULT_THRESHOLD;
         npeers_ff <= NPEER_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_THRESHOLD: thr_ff <= csr_data;
            CSR_PEERS:     npeers_ff <= csr_data[NPEER_W-1:0];
            default:       ;
         endcase
      end
   end

   // effective peer count and threshold
   logic [CNT_W-1:0] n_eff;
   logic [ACT_W-1:0] thr_eff;
   always_comb begin
      if ({{(32-NPEER_W){1'b0}}, npeers_ff} > 32'(MAX_PEERS)) n_eff = CNT_W'(MAX_PEERS);
      else n_eff = CNT_W'(npeers_ff);
      thr_eff = (thr_ff == '0) ? DEFAULT_THRESHOLD : thr_ff;
   end

   // counter memories
   logic [ACT_W-1:0]  act_mem [MAX_PEERS];
   logic [PEND_W-1:0] pend_mem [MAX_PEERS];
   logic [IDX_W-1:0]  rd_addr, wr_addr;
   logic              wr_en;
   logic [ACT_W-1:0]  wr_act, rd_act_ff;
   logic [PEND_W-1:0] wr_pend, rd_pend_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         act_mem[wr_addr]  <= wr_act;
         pend_mem[wr_addr] <= wr_pend;
      end
      rd_act_ff  <= act_mem[rd_addr];
      rd_pend_ff <= pend_mem[rd_addr];
   end

   // item registers and scan state
   state_type         state_ff, state_in;
   logic              func_ff, func_in;
   logic [IDX_W-1:0]  tgt_ff, tgt_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [RND_W-1:0]  rnd_ff, rnd_in;
   logic [CNT_W-1:0]  addr_ff, addr_in;
   logic              rdv_ff, rdv_in;
   logic [IDX_W-1:0]  ridx_ff, ridx_in;
   logic              over_ff, over_in;
   logic [PEND_W-1:0] best_ff, best_in;
   logic [CNT_W-1:0]  ties_ff, ties_in;
   logic [ACT_W-1:0]  bact_ff, bact_in;
   logic [CNT_W-1:0]  tact_ff, tact_in;
   logic [CNT_W-1:0]  pick_ff, pick_in;
   logic [CNT_W-1:0]  seen_ff, seen_in;
   logic              found_ff, found_in;
   logic              ov_ff, ov_in;
   logic [PEER_W-1:0] opeer_ff, opeer_in;
   logic              oover_ff, oover_in;
   logic [1:0]        ostat_ff, ostat_in;

   div_req_type dreq;
   div_rsp_type drsp;

   tllpp_mod u_mod (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   // candidate key of the entry just read
   logic              cand;
   logic [PEND_W-1:0] key;
   logic              last_addr;
   logic [ACT_W:0]    act_inc;
   logic [PEND_W:0]   pend_sum;

   always_comb begin
      cand = over_ff || (rd_act_ff < thr_eff);
      key  = over_ff ? {{(PEND_W-ACT_W){1'b0}}, rd_act_ff} : rd_pend_ff;
      last_addr = (addr_ff == n_eff);
      act_inc  = {1'b0, rd_act_ff} + 1'b1;
      pend_sum = {1'b0, rd_pend_ff} + {{(PEND_W+1-LEN_W){1'b0}}, len_ff};
   end

   // sequencer: next state and outputs
   always_comb begin
      state_in = state_ff;
      func_in  = func_ff;
      tgt_in   = tgt_ff;
      len_in   = len_ff;
      rnd_in   = rnd_ff;
      addr_in  = addr_ff;
      rdv_in   = 1'b0;
      ridx_in  = addr_ff[IDX_W-1:0];
      over_in  = over_ff;
      best_in  = best_ff;
      ties_in  = ties_ff;
      bact_in  = bact_ff;
      tact_in  = tact_ff;
      pick_in  = pick_ff;
      seen_in  = seen_ff;
      found_in = found_ff;
      ov_in    = 1'b0;
      opeer_in = opeer_ff;
      oover_in = oover_ff;
      ostat_in = ostat_ff;
      rd_addr  = addr_ff[IDX_W-1:0];
      wr_en    = 1'b0;
      wr_addr  = addr_ff[IDX_W-1:0];
      wr_act   = '0;
      wr_pend  = '0;
      dreq.start    = 1'b0;
      dreq.dividend = rnd_ff;
      dreq.divisor  = ties_ff;
      busy = (state_ff != ST_IDLE);

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == CNT_W'(MAX_PEERS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               func_in = req_func;
               tgt_in  = IDX_W'(req_peer_index);
               len_in  = req_job_len;
               rnd_in  = req_random_value;
               addr_in = '0;
               over_in = 1'b1;
               ties_in = '0;
               tact_in = '0;
               seen_in = '0;
               found_in = 1'b0;
               if (n_eff == '0) begin
                  opeer_in = '0; oover_in = 1'b0; ostat_in = STATUS_NO_PEERS;
                  state_in = ST_DONE;
               end else if (req_func == FUNC_RELEASE) begin
                  if ({1'b0, req_peer_index} >= n_eff) begin
                     opeer_in = req_peer_index; oover_in = 1'b0;
                     ostat_in = STATUS_RANGE;
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_RMW_RD;
                  end
               end else begin
                  state_in = ST_MIN;
               end
            end
         end
         // one pass: overload check, least active count and least pending
         // length under threshold, each with its tie count
         ST_MIN: begin
            if (!last_addr) begin
               rdv_in  = 1'b1;
               addr_in = addr_ff + 1'b1;
            end
            if (rdv_ff) begin
               if (tact_ff == '0 || rd_act_ff < bact_ff) begin
                  bact_in = rd_act_ff; tact_in = CNT_W'(1);
               end else if (rd_act_ff == bact_ff) begin
                  tact_in = tact_ff + 1'b1;
               end
               if (rd_act_ff < thr_eff) begin
                  over_in = 1'b0;
                  if (ties_ff == '0 || rd_pend_ff < best_ff) begin
                     best_in = rd_pend_ff; ties_in = CNT_W'(1);
                  end else if (rd_pend_ff == best_ff) begin
                     ties_in = ties_ff + 1'b1;
                  end
               end
            end
            if (last_addr && !rdv_ff) begin
               // all overloaded: fall back to the active count key
               if (over_ff) begin
                  best_in = {{(PEND_W-ACT_W){1'b0}}, bact_ff};
                  ties_in = tact_ff;
               end
               dreq.divisor = over_ff ? tact_ff : ties_ff;
               dreq.start = 1'b1;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            addr_in = '0;
            if (drsp.done) begin
               pick_in  = drsp.remainder;
               state_in = ST_SEL;
            end
         end
         // locate the pick-th tied candidate
         ST_SEL: begin
            if (!last_addr && !found_ff) begin
               rdv_in  = 1'b1;
               addr_in = addr_ff + 1'b1;
            end
            if (rdv_ff && !found_ff && cand && key == best_ff) begin
               if (seen_ff == pick_ff) begin
                  found_in = 1'b1;
                  tgt_in   = ridx_ff;
               end
               seen_in = seen_ff + 1'b1;
            end
            if (found_ff || (last_addr && !rdv_ff)) state_in = ST_RMW_RD;
         end
         ST_RMW_RD: begin
            rd_addr  = tgt_ff;
            state_in = ST_RMW_WR;
         end
         // write back updated counters
         ST_RMW_WR: begin
            wr_en   = 1'b1;
            wr_addr = tgt_ff;
            if (func_ff == FUNC_RELEASE) begin
               wr_act  = (rd_act_ff != '0) ? rd_act_ff - 1'b1 : '0;
               wr_pend = (rd_pend_ff > {{(PEND_W-LEN_W){1'b0}}, len_ff})
                         ? rd_pend_ff - {{(PEND_W-LEN_W){1'b0}}, len_ff} : '0;
               oover_in = 1'b0;
            end else begin
               wr_act  = act_inc[ACT_W] ? rd_act_ff : act_inc[ACT_W-1:0];
               wr_pend = pend_sum[PEND_W] ? {PEND_W{1'b1}} : pend_sum[PEND_W-1:0];
               oover_in = over_ff;
            end
            opeer_in = PEER_W'(tgt_ff);
            ostat_in = STATUS_OK;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            ov_in    = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff  <= '0;
         rdv_ff   <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         rdv_ff   <= rdv_in;
         ov_ff    <= ov_in;
      end
      func_ff  <= func_in;
      tgt_ff   <= tgt_in;
      len_ff   <= len_in;
      rnd_ff   <= rnd_in;
      ridx_ff  <= ridx_in;
      over_ff  <= over_in;
      best_ff  <= best_in;
      ties_ff  <= ties_in;
      bact_ff  <= bact_in;
      tact_ff  <= tact_in;
      pick_ff  <= pick_in;
      seen_ff  <= seen_in;
      found_ff <= found_in;
      opeer_ff <= opeer_in;
      oover_ff <= oover_in;
      ostat_ff <= ostat_in;
   end

   assign rsp_valid          = ov_ff;
   assign rsp_chosen_peer    = opeer_ff;
   assign rsp_all_overloaded = oover_ff;
   assign rsp_status         = ostat_ff;

   // checks
   a_no_valid_in_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result during reset");
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("start not taken");
   a_release_never_over: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> !rsp_all_overloaded)
      else $error("error result flagged overloaded");
   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double result");

endmodule

FILE: sim/threshold_least_load_peer_picker_test.sv
// ----------------------------------------------------------------------------
// threshold_least_load_peer_picker_test
// Self-checking bench: random assign/release traffic across several threshold
// and peer-count settings, each response checked against a behavioral picker.
// ----------------------------------------------------------------------------
module threshold_least_load_peer_picker_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tllpp_pkg::*;

   typedef struct packed {
      logic              func;
      logic [PEER_W-1:0] peer_index;
      logic [LEN_W-1:0]  job_len;
      logic [RND_W-1:0]  random_value;
   } pick_req_t;

   typedef struct packed {
      logic [PEER_W-1:0] chosen_peer;
      logic              all_overloaded;
      logic [1:0]        status;
   } pick_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_func = 1'b0;
   logic [PEER_W-1:0] req_peer_index = '0;
   logic [LEN_W-1:0] req_job_len = '0;
   logic [RND_W-1:0] req_random_value = '0;
   logic rsp_valid;
   logic [PEER_W-1:0] rsp_chosen_peer;
   logic rsp_all_overloaded;
   logic [1:0] rsp_status;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = 1'b0;
   logic [31:0] csr_data = '0;

   threshold_least_load_peer_picker dut (.*);

   // model state
   logic [ACT_W-1:0]  act_cnt [MAX_PEERS];
   logic [PEND_W-1:0] pend_len [MAX_PEERS];
   logic [31:0]       thresh_reg;
   logic [NPEER_W-1:0] peers_reg;

   pick_req_t pending_items[$];
   pick_rsp_t expected_picks[$];
   int errors = 0;
   int watchdog = 0;
   bit gaps_on = 1'b1;
   bit hold_sender = 1'b0;
   logic busy_seen = 1'b0;

   initial forever #5 clock = ~clock;

   function automatic pick_rsp_t predict_pick(pick_req_t it);
      pick_rsp_t r;
      int n, ties, pick, seen, chosen;
      logic [63:0] thr, best, key;
      bit over;
      r = '0;
      n = (peers_reg > MAX_PEERS) ? MAX_PEERS : peers_reg;
      thr = (thresh_reg == 0) ? DEFAULT_THRESHOLD : thresh_reg;
      if (n == 0) begin
         r.status = STATUS_NO_PEERS;
         return r;
      end
      if (it.func == FUNC_RELEASE) begin
         r.chosen_peer = it.peer_index;
         if (it.peer_index >= n) begin
            r.status = STATUS_RANGE;
            return r;
         end
         if (act_cnt[it.peer_index] != 0) act_cnt[it.peer_index]--;
         pend_len[it.peer_index] = (pend_len[it.peer_index] > it.job_len) ?
            pend_len[it.peer_index] - it.job_len : '0;
         r.status = STATUS_OK;
         return r;
      end
      over = 1'b1;
      for (int i = 0; i < n; i++) if (act_cnt[i] < thr) over = 1'b0;
      ties = 0;
      best = 0;
      for (int i = 0; i < n; i++) begin
         if (!over && act_cnt[i] >= thr) continue;
         key = over ? act_cnt[i] : pend_len[i];
         if (ties == 0 || key < best) begin
            best = key;
            ties = 1;
         end else if (key == best) ties++;
      end
      pick = it.random_value % ties;
      seen = 0;
      chosen = 0;
      for (int i = 0; i < n; i++) begin
         if (!over && act_cnt[i] >= thr) continue;
         key = over ? act_cnt[i] : pend_len[i];
         if (key == best) begin
            if (seen == pick) begin
               chosen = i;
               break;
            end
            seen++;
         end
      end
      if (act_cnt[chosen] != '1) act_cnt[chosen]++;
      pend_len[chosen] = ({1'b0, pend_len[chosen]} + it.job_len > {1'b0, {PEND_W{1'b1}}})
         ? '1 : pend_len[chosen] + it.job_len;
      r.chosen_peer = chosen[PEER_W-1:0];
      r.all_overloaded = over;
      r.status = STATUS_OK;
      return r;
   endfunction

   // driver: one transfer per accepted start, random idle bursts
   int idle_left = 0;
   always @(negedge clock) begin
      // hold the item while it has not been taken
      if (!reset && !(start && busy_seen)) begin
         if (pending_items.size() != 0 && !hold_sender && idle_left == 0 &&
             !(gaps_on && $urandom_range(0, 5) == 0)) begin
            pick_req_t it;
            it = pending_items.pop_front();
            req_func <= it.func;
            req_peer_index <= it.peer_index;
            req_job_len <= it.job_len;
            req_random_value <= it.random_value;
            start <= 1'b1;
            if (gaps_on && $urandom_range(0, 7) == 0) idle_left = $urandom_range(1, 11);
         end else begin
            start <= 1'b0;
            if (idle_left > 0) idle_left--;
         end
      end
   end

   // prediction happens at acceptance; monitor compares each strobed result
   always @(posedge clock) begin
      busy_seen <= busy;
      if (reset) watchdog <= 0;
      else begin
         if (start && !busy) begin
            pick_req_t it;
            it = '{req_func, req_peer_index, req_job_len, req_random_value};
            expected_picks.push_back(predict_pick(it));
         end
         if (rsp_valid) begin
            pick_rsp_t exp_r;
            if (expected_picks.size() == 0) begin
               $display("%0t: unexpected result peer %0d", $time, rsp_chosen_peer);
               errors++;
            end else begin
               exp_r = expected_picks.pop_front();
               if (exp_r.chosen_peer !== rsp_chosen_peer) begin
                  $display("%0t: chosen_peer expected %0d actual %0d",
                           $time, exp_r.chosen_peer, rsp_chosen_peer);
                  errors++;
               end
               if (exp_r.all_overloaded !== rsp_all_overloaded) begin
                  $display("%0t: all_overloaded expected %0d actual %0d",
                           $time, exp_r.all_overloaded, rsp_all_overloaded);
                  errors++;
               end
               if (exp_r.status !== rsp_status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, exp_r.status, rsp_status);
                  errors++;
               end
            end
         end
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) watchdog <= 0;
         else watchdog <= watchdog + 1;
         if (watchdog > 20000) begin
            $display("threshold_least_load_peer_picker_test NOT OK");
            $finish;
         end
      end
   end

   task automatic write_reg(input logic idx, input logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_THRESHOLD) thresh_reg = val;
      else peers_reg = val[NPEER_W-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_picks();
      wait (pending_items.size() == 0);
      @(posedge clock);
      while (start || busy || expected_picks.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic pick_req_t rand_item(int n);
      pick_req_t it;
      it.func = ($urandom_range(0, 2) == 0);
      it.peer_index = ($urandom_range(0, 9) == 0) ? PEER_W'($urandom_range(0, 511))
                      : PEER_W'($urandom_range(0, (n > 0) ? n - 1 : 0));
      case ($urandom_range(0, 3))
         0: it.job_len = $urandom_range(0, 3);
         1: it.job_len = '1;
         default: it.job_len = $urandom();
      endcase
      it.random_value = ($urandom_range(0, 3) == 0) ? {RND_W{1'b1}} : RND_W'($urandom());
      return it;
   endfunction

   task automatic add_item(input logic f, input int p, input logic [31:0] len,
                           input logic [30:0] rv);
      pending_items.push_back('{f, p[PEER_W-1:0], len, rv});
   endtask

   initial begin
      int n_cfg [6] = '{4, 1, 16, 0, 3, 512};
      logic [31:0] t_cfg [6] = '{2, 1, 3, 5, 0, 32'hFFFF_FFFF};
      for (int i = 0; i < MAX_PEERS; i++) begin
         act_cnt[i] = '0;
         pend_len[i] = '0;
      end
      thresh_reg = DEFAULT_THRESHOLD;
      peers_reg = 1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset settings, length extremes, saturating release
      add_item(FUNC_ASSIGN, 0, '1, '1);
      add_item(FUNC_ASSIGN, 0, '1, 0);
      add_item(FUNC_RELEASE, 0, 0, 0);
      add_item(FUNC_RELEASE, 1, 5, 0);
      add_item(FUNC_RELEASE, 511, 5, '1);
      add_item(FUNC_RELEASE, 0, '1, 0);
      add_item(FUNC_RELEASE, 0, '1, 0);
      drain_picks();

      for (int ph = 0; ph < 6; ph++) begin
         write_reg(CSR_THRESHOLD, t_cfg[ph]);
         write_reg(CSR_PEERS, n_cfg[ph]);
         if (ph == 0) begin
            // overload path: push all four peers over threshold 2
            for (int k = 0; k < 10; k++) add_item(FUNC_ASSIGN, 0, k, k);
            add_item(FUNC_RELEASE, 4, 1, 0);
            add_item(FUNC_RELEASE, 3, 0, 0);
         end
         if (ph == 5) gaps_on = 1'b0;
         for (int k = 0; k < ((ph == 5) ? 20 : 100); k++) begin
            add_item(0, 0, 0, 0);
            pending_items[$] = rand_item(n_cfg[ph]);
         end
         if (ph == 2) begin
            // hold off until everything in flight has come back
            wait (pending_items.size() == 60);
            hold_sender = 1'b1;
            while (busy || start || expected_picks.size() != 0) @(posedge clock);
            hold_sender = 1'b0;
         end
         drain_picks();
      end
      write_reg(CSR_PEERS, 1023);
      for (int k = 0; k < 5; k++) begin
         add_item(0, 0, 0, 0);
         pending_items[$] = rand_item(512);
      end
      drain_picks();
      if (errors == 0)
         $display("threshold_least_load_peer_picker_test OK");
      else
         $display("threshold_least_load_peer_picker_test NOT OK");
      $finish;
   end
endmodule

FILE: threshold_least_load_peer_picker.f
hw/rtl/tllpp_pkg.sv
hw/rtl/tllpp_mod.sv
hw/rtl/threshold_least_load_peer_picker.sv
sim/threshold_least_load_peer_picker_test.sv
